FILE: hw/rtl/vmg_pkg.sv
// Package for the voxel marker grid engine: command codes, field widths,
// the decoded job record, the result record and the engine state type.
// No dependencies.
package vmg_pkg;

  localparam int COORD_W = 5;
  localparam int HALF_W  = 4;
  localparam int VAL_W   = 2;
  // Decoded bounds never exceed 31 + 15, whatever the grid size.
  localparam int BOUND_W = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [BOUND_W-1:0] bound_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t   op;
    logic   skip;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    bound_t x_lo;
    bound_t x_hi;
    bound_t y_lo;
    bound_t y_hi;
    bound_t z_lo;
    bound_t z_hi;
    val_t   value;
  } job_t;

  typedef struct packed {
    val_t cell_value;
    logic hit;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN
  } eng_state_t;

endpackage

FILE: hw/rtl/vmg_if.sv
// Channel interfaces of the voxel marker grid engine: command in, result out.
// Depends on vmg_pkg.
interface vmg_in_if;
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  vmg_pkg::coord_t x_lo;
  vmg_pkg::coord_t y_lo;
  vmg_pkg::coord_t z_lo;
  vmg_pkg::coord_t x_hi;
  vmg_pkg::coord_t y_hi;
  vmg_pkg::coord_t z_hi;
  vmg_pkg::half_t  half_x;
  vmg_pkg::half_t  half_y;
  vmg_pkg::half_t  half_z;
  vmg_pkg::val_t   value;

  modport source (
    output valid, cmd, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi, half_x, half_y, half_z, value,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi, half_x, half_y, half_z, value,
    output ready
  );
endinterface

interface vmg_out_if;
  logic          valid;
  logic          ready;
  vmg_pkg::val_t cell_value;
  logic          hit;

  modport source (output valid, cell_value, hit, input ready);
  modport sink (input valid, cell_value, hit, output ready);
endinterface

FILE: hw/rtl/vmg_front.sv
// Front end: takes commands from the input channel, clips bounds and flags
// commands that touch no cell, then pushes a decoded job. Depends on vmg_pkg, vmg_if.
module vmg_front #(
  parameter int AXIS_CELLS = 16
) (
  input  logic          clearing,
  vmg_in_if.sink        req,
  input  logic          q_full,
  output logic          q_push,
  output vmg_pkg::job_t job
);

  localparam int CMP_W = ($clog2(AXIS_CELLS + 1) > vmg_pkg::BOUND_W) ?
                         $clog2(AXIS_CELLS + 1) : vmg_pkg::BOUND_W;
  localparam logic [CMP_W-1:0] AXIS_V = CMP_W'(AXIS_CELLS);

  logic [CMP_W-1:0] cx, cy, cz;
  logic [CMP_W-1:0] qx, qy, qz;
  logic [CMP_W-1:0] hx, hy, hz;
  logic [CMP_W-1:0] sx, sy, sz;
  logic [CMP_W-1:0] lx, ly, lz;
  logic [CMP_W-1:0] ux, uy, uz;
  logic             in_grid;
  logic             empty_box;
  vmg_pkg::cmd_t    op;

  assign req.ready = !q_full && !clearing;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    op = vmg_pkg::cmd_t'(req.cmd);
    cx = CMP_W'(req.x_lo);
    cy = CMP_W'(req.y_lo);
    cz = CMP_W'(req.z_lo);
    qx = CMP_W'(req.x_hi);
    qy = CMP_W'(req.y_hi);
    qz = CMP_W'(req.z_hi);
    hx = CMP_W'(req.half_x);
    hy = CMP_W'(req.half_y);
    hz = CMP_W'(req.half_z);
    sx = cx + hx;
    sy = cy + hy;
    sz = cz + hz;
    in_grid = (cx < AXIS_V) && (cy < AXIS_V) && (cz < AXIS_V);

    case (op)
      vmg_pkg::CMD_QUERY: begin
        lx = cx;
        ly = cy;
        lz = cz;
        ux = (qx > AXIS_V) ? AXIS_V : qx;
        uy = (qy > AXIS_V) ? AXIS_V : qy;
        uz = (qz > AXIS_V) ? AXIS_V : qz;
      end
      vmg_pkg::CMD_MARK: begin
        // Saturate the low corner at zero, clip the high corner to the grid.
        lx = (cx >= hx) ? cx - hx : '0;
        ly = (cy >= hy) ? cy - hy : '0;
        lz = (cz >= hz) ? cz - hz : '0;
        ux = (sx > AXIS_V) ? AXIS_V : sx;
        uy = (sy > AXIS_V) ? AXIS_V : sy;
        uz = (sz > AXIS_V) ? AXIS_V : sz;
      end
      default: begin
        // Single cell access is a one-cell box.
        lx = cx;
        ly = cy;
        lz = cz;
        ux = cx + CMP_W'(1);
        uy = cy + CMP_W'(1);
        uz = cz + CMP_W'(1);
      end
    endcase

    empty_box = (lx >= ux) || (ly >= uy) || (lz >= uz);

    job.op    = op;
    job.skip  = (op == vmg_pkg::CMD_QUERY) ? empty_box : (!in_grid || empty_box);
    job.c_x   = req.x_lo;
    job.c_y   = req.y_lo;
    job.c_z   = req.z_lo;
    job.x_lo  = vmg_pkg::bound_t'(lx);
    job.x_hi  = vmg_pkg::bound_t'(ux);
    job.y_lo  = vmg_pkg::bound_t'(ly);
    job.y_hi  = vmg_pkg::bound_t'(uy);
    job.z_lo  = vmg_pkg::bound_t'(lz);
    job.z_hi  = vmg_pkg::bound_t'(uz);
    job.value = req.value;
  end

endmodule

FILE: hw/rtl/vmg_queue.sv
// Two-entry job queue between front and back end.
// Depends on vmg_pkg.
module vmg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vmg_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output vmg_pkg::job_t head
);

  vmg_pkg::job_t                entries [vmg_pkg::QUEUE_DEPTH];
  logic [vmg_pkg::QPTR_W-1:0]   wr_ptr;
  logic [vmg_pkg::QPTR_W-1:0]   rd_ptr;
  logic [vmg_pkg::QPTR_W:0]     count;

  assign full       = (count == (vmg_pkg::QPTR_W + 1)'(vmg_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

FILE: hw/rtl/vmg_back.sv
// Back end: row-wide cell memory and the sequencer that carries out jobs
// one row per cycle, plus the clearing pass and the result register. Depends on vmg_pkg.
module vmg_back #(
  parameter int AXIS_CELLS = 16,
  parameter int CELL_BITS  = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  vmg_pkg::job_t    head,
  output logic             pop,
  output logic             clearing,
  output logic             res_valid,
  output vmg_pkg::result_t res,
  input  logic             res_take
);

  localparam int ROW_BITS = AXIS_CELLS * CELL_BITS;
  localparam int ROWS     = AXIS_CELLS * AXIS_CELLS;
  localparam int AW       = $clog2(ROWS);
  localparam int CMP_W    = ($clog2(AXIS_CELLS + 1) > vmg_pkg::BOUND_W) ?
                            $clog2(AXIS_CELLS + 1) : vmg_pkg::BOUND_W;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  vmg_pkg::eng_state_t state, state_next;
  vmg_pkg::job_t       job, job_next;
  vmg_pkg::bound_t     y, y_next;
  vmg_pkg::bound_t     z, z_next;
  logic                pend, pend_next;
  logic [AW-1:0]       pend_addr, pend_addr_next;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [CELL_BITS-1:0] fill, fill_next;
  logic                acc_hit, acc_hit_next;
  logic                res_valid_next;
  vmg_pkg::result_t    res_next;

  logic [CELL_BITS-1:0] mask;
  logic [CELL_BITS-1:0] cur;
  logic [CELL_BITS-1:0] pick_cell;
  logic [CELL_BITS-1:0] center_cell;
  logic                 sel;
  logic                 row_hit;
  logic [ROW_BITS-1:0]  merged;

  function automatic logic [AW-1:0] row_addr(input vmg_pkg::bound_t yy,
                                             input vmg_pkg::bound_t zz);
    return AW'(32'(zz) * AXIS_CELLS + 32'(yy));
  endfunction

  assign clearing = (state == vmg_pkg::ST_CLEAR);

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Per-cell view of the row just read: box hit, picked cell, merged fill.
  always_comb begin
    mask        = CELL_BITS'(job.value);
    row_hit     = 1'b0;
    pick_cell   = '0;
    center_cell = '0;
    merged      = rd_data;
    for (int i = 0; i < AXIS_CELLS; i++) begin
      cur = rd_data[i*CELL_BITS +: CELL_BITS];
      sel = (CMP_W'(i) >= CMP_W'(job.x_lo)) && (CMP_W'(i) < CMP_W'(job.x_hi));
      if (sel && ((cur & mask) != '0)) row_hit = 1'b1;
      if (CMP_W'(i) == CMP_W'(job.x_lo)) pick_cell = cur;
      if (CMP_W'(i) == CMP_W'(job.c_x)) center_cell = cur;
      if (sel) merged[i*CELL_BITS +: CELL_BITS] = fill;
    end
  end

  always_comb begin
    state_next     = state;
    job_next       = job;
    y_next         = y;
    z_next         = z;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    clr_addr_next  = clr_addr;
    fill_next      = fill;
    acc_hit_next   = acc_hit;
    res_valid_next = res_valid && !res_take;
    res_next       = res;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = row_addr(y, z);
    wr_en          = 1'b0;
    wr_addr        = pend_addr;
    wr_data        = merged;

    case (state)
      vmg_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(ROWS - 1)) state_next = vmg_pkg::ST_IDLE;
      end
      vmg_pkg::ST_IDLE: begin
        if (head_valid && !res_valid) begin
          pop          = 1'b1;
          job_next     = head;
          y_next       = head.y_lo;
          z_next       = head.z_lo;
          acc_hit_next = 1'b0;
          fill_next    = CELL_BITS'(head.value);
          if (head.skip) begin
            // Nothing to touch: answer zero at once.
            res_valid_next = 1'b1;
            res_next       = '0;
          end else if (head.op == vmg_pkg::CMD_MARK) begin
            rd_en      = 1'b1;
            rd_addr    = row_addr(vmg_pkg::bound_t'(head.c_y), vmg_pkg::bound_t'(head.c_z));
            state_next = vmg_pkg::ST_CENTER;
          end else begin
            state_next = vmg_pkg::ST_SCAN;
          end
        end
      end
      vmg_pkg::ST_CENTER: begin
        fill_next  = fill | center_cell;
        state_next = vmg_pkg::ST_SCAN;
      end
      vmg_pkg::ST_SCAN: begin
        rd_en          = 1'b1;
        pend_next      = 1'b1;
        pend_addr_next = rd_addr;
        if (pend) begin
          if (job.op == vmg_pkg::CMD_QUERY) acc_hit_next = acc_hit | row_hit;
          if (job.op == vmg_pkg::CMD_WRITE || job.op == vmg_pkg::CMD_MARK) wr_en = 1'b1;
        end
        if (y + 1'b1 == job.y_hi) begin
          y_next = job.y_lo;
          z_next = z + 1'b1;
          if (z + 1'b1 == job.z_hi) state_next = vmg_pkg::ST_DRAIN;
        end else begin
          y_next = y + 1'b1;
        end
      end
      vmg_pkg::ST_DRAIN: begin
        // Retire the last row and post the result.
        if (job.op == vmg_pkg::CMD_WRITE || job.op == vmg_pkg::CMD_MARK) wr_en = 1'b1;
        pend_next           = 1'b0;
        res_valid_next      = 1'b1;
        res_next.hit        = (job.op == vmg_pkg::CMD_QUERY) && (acc_hit || row_hit);
        res_next.cell_value = (job.op == vmg_pkg::CMD_READ) ? vmg_pkg::val_t'(pick_cell) : '0;
        state_next          = vmg_pkg::ST_IDLE;
      end
      default: begin
        state_next = vmg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vmg_pkg::ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job       <= job_next;
    y         <= y_next;
    z         <= z_next;
    pend_addr <= pend_addr_next;
    fill      <= fill_next;
    acc_hit   <= acc_hit_next;
    res       <= res_next;
  end

endmodule

FILE: hw/rtl/voxel_marker_grid_engine_unit.sv
// Voxel marker grid engine. A read or write touches one row; a box query and a mark cube
// walk the y/z rows of the clipped box, one row of AXIS_CELLS cells per cycle, and a mark
// first reads its center row. A command that touches no cell is answered without a scan.
// Throughput: one command in the back end at a time, the next starts the cycle after the
// result transfer. After reset a clearing pass zeroes the grid row by row, taking no input.
// Uses vmg_pkg, vmg_if and submodules.
module voxel_marker_grid_engine_unit #(
  parameter int AXIS_CELLS = 16,
  parameter int CELL_BITS  = 2
) (
  input  logic      clk,
  input  logic      rst,
  vmg_in_if.sink    req,
  vmg_out_if.source rsp
);

  // Front end: classify and clip, hand decoded jobs to the queue.
  logic             clearing;
  logic             q_full;
  logic             q_push;
  vmg_pkg::job_t    q_in;

  // Queue head toward the back end.
  logic             q_pop;
  logic             q_valid;
  vmg_pkg::job_t    q_head;

  // Result register of the back end.
  logic             res_valid;
  vmg_pkg::result_t res;
  logic             res_take;

  vmg_front #(
    .AXIS_CELLS (AXIS_CELLS)
  ) u_front (
    .clearing (clearing),
    .req      (req),
    .q_full   (q_full),
    .q_push   (q_push),
    .job      (q_in)
  );

  // Hold up to two decoded jobs so the input keeps moving while a long
  // scan runs or a result waits to be taken.
  vmg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back end: walk the box row by row against the grid memory.
  vmg_back #(
    .AXIS_CELLS (AXIS_CELLS),
    .CELL_BITS  (CELL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .clearing   (clearing),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // Drive the result channel straight from the result register.
  assign rsp.valid      = res_valid;
  assign rsp.cell_value = res.cell_value;
  assign rsp.hit        = res.hit;
  assign res_take       = rsp.valid && rsp.ready;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for voxel_marker_grid_engine_unit: drives grid commands
// over the request channel and checks each result against a local grid model.
// Depends on vmg_pkg, vmg_if and the engine RTL.
module tb_top;
  import vmg_pkg::*;

  localparam int GRID_AXIS  = 16;
  localparam int GRID_CELLS = GRID_AXIS * GRID_AXIS * GRID_AXIS;
  localparam int RANDOM_CMDS = 1350;
  // Worst single command: a full-grid mark, which scans all 256 rows.
  localparam int DRAIN_CYCLES = 400;

  // One command as the bench sees it, all fields at port widths.
  typedef struct packed {
    cmd_t   op;
    coord_t x_lo;
    coord_t y_lo;
    coord_t z_lo;
    coord_t x_hi;
    coord_t y_hi;
    coord_t z_hi;
    half_t  half_x;
    half_t  half_y;
    half_t  half_z;
    val_t   value;
  } grid_cmd_t;

  logic clk;
  logic rst;

  vmg_in_if  req_if ();
  vmg_out_if rsp_if ();

  voxel_marker_grid_engine_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Shadow copy of the grid, updated in transfer order on the request side.
  val_t voxel_map [0:GRID_CELLS-1];

  grid_cmd_t pending_cmds [$];
  result_t   expected_results [$];

  int total_cmds;
  int accepted_count;
  int result_count;
  int mismatch_count;

  // Sender burst shaping.
  int burst_left;
  int gap_left;
  grid_cmd_t cur_cmd;

  // Receiver stall pattern: a 16-bit ready mask, reloaded after its last bit is used.
  logic [15:0] ready_pattern;
  int          pattern_pos;

  always #5 clk = ~clk;

  function automatic int cell_addr(input int x, input int y, input int z);
    return x + GRID_AXIS * (y + GRID_AXIS * z);
  endfunction

  function automatic int clip_upper(input int v);
    return (v > GRID_AXIS) ? GRID_AXIS : v;
  endfunction

  // Apply one command to the shadow grid and return the result it must give.
  function automatic result_t apply_grid_cmd(input grid_cmd_t c);
    result_t r;
    int x, y, z;
    int xl, yl, zl, xh, yh, zh;
    bit on_grid;
    val_t fill;
    r = '0;
    on_grid = (c.x_lo < GRID_AXIS) && (c.y_lo < GRID_AXIS) && (c.z_lo < GRID_AXIS);
    case (c.op)
      CMD_READ: begin
        if (on_grid) r.cell_value = voxel_map[cell_addr(c.x_lo, c.y_lo, c.z_lo)];
      end
      CMD_WRITE: begin
        if (on_grid) voxel_map[cell_addr(c.x_lo, c.y_lo, c.z_lo)] = c.value;
      end
      CMD_QUERY: begin
        // Clip the upper bounds only; a low bound past its upper bound is empty.
        xh = clip_upper(c.x_hi);
        yh = clip_upper(c.y_hi);
        zh = clip_upper(c.z_hi);
        for (z = c.z_lo; z < zh; z++)
          for (y = c.y_lo; y < yh; y++)
            for (x = c.x_lo; x < xh; x++)
              if ((voxel_map[cell_addr(x, y, z)] & c.value) != '0) r.hit = 1'b1;
      end
      default: begin
        // Mark: the fill is the value ORed with the center's value from before the command.
        if (on_grid) begin
          fill = c.value | voxel_map[cell_addr(c.x_lo, c.y_lo, c.z_lo)];
          xl = (c.x_lo >= c.half_x) ? c.x_lo - c.half_x : 0;
          yl = (c.y_lo >= c.half_y) ? c.y_lo - c.half_y : 0;
          zl = (c.z_lo >= c.half_z) ? c.z_lo - c.half_z : 0;
          xh = clip_upper(c.x_lo + c.half_x);
          yh = clip_upper(c.y_lo + c.half_y);
          zh = clip_upper(c.z_lo + c.half_z);
          for (z = zl; z < zh; z++)
            for (y = yl; y < yh; y++)
              for (x = xl; x < xh; x++)
                voxel_map[cell_addr(x, y, z)] = fill;
        end
      end
    endcase
    return r;
  endfunction

  function automatic grid_cmd_t make_cmd(input cmd_t op, input int xl, input int yl,
                                         input int zl, input int xh, input int yh,
                                         input int zh, input int hx, input int hy,
                                         input int hz, input int v);
    grid_cmd_t c;
    c.op = op;
    c.x_lo = coord_t'(xl);
    c.y_lo = coord_t'(yl);
    c.z_lo = coord_t'(zl);
    c.x_hi = coord_t'(xh);
    c.y_hi = coord_t'(yh);
    c.z_hi = coord_t'(zh);
    c.half_x = half_t'(hx);
    c.half_y = half_t'(hy);
    c.half_z = half_t'(hz);
    c.value = val_t'(v);
    return c;
  endfunction

  // Append one command to the tail of the pending list.
  function automatic void add_cmd(input grid_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Mostly on-grid, sometimes the first cell past the edge, rarely far out.
  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 88) return $urandom_range(0, GRID_AXIS - 1);
    if (pick < 97) return GRID_AXIS;
    return $urandom_range(GRID_AXIS + 1, 31);
  endfunction

  // Small boxes and cubes keep the run short; a few span the whole grid.
  function automatic grid_cmd_t rand_grid_cmd();
    grid_cmd_t c;
    int pick;
    c = make_cmd(CMD_READ, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      c.op = CMD_WRITE;
    end else if (pick < 52) begin
      c.op = CMD_READ;
    end else if (pick < 78) begin
      c.op = CMD_QUERY;
      if ($urandom_range(0, 19) == 0) begin
        c.x_lo = '0;
        c.y_lo = '0;
        c.z_lo = '0;
        c.x_hi = $urandom_range(0, 1) ? coord_t'(GRID_AXIS) : coord_t'(31);
        c.y_hi = coord_t'(GRID_AXIS);
        c.z_hi = coord_t'(GRID_AXIS);
      end else begin
        c.x_hi = coord_t'(((c.x_lo + $urandom_range(0, 4)) > 31) ? 31 : c.x_lo + $urandom_range(0, 4));
        c.y_hi = coord_t'(((c.y_lo + $urandom_range(0, 4)) > 31) ? 31 : c.y_lo + $urandom_range(0, 4));
        c.z_hi = coord_t'(((c.z_lo + $urandom_range(0, 4)) > 31) ? 31 : c.z_lo + $urandom_range(0, 4));
      end
    end else begin
      c.op = CMD_MARK;
      if ($urandom_range(0, 24) != 0) begin
        c.half_x = half_t'($urandom_range(0, 3));
        c.half_y = half_t'($urandom_range(0, 3));
        c.half_z = half_t'($urandom_range(0, 3));
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: result %0d %s: expected %0d, got %0d",
             $time, result_count, what, want, got);
    mismatch_count++;
  endtask

  // Request driver: bursts of back-to-back transfers separated by random gaps.
  // Hold the payload while valid is high and ready is low; update the shadow
  // grid at the edge where the transfer completes.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.insert(expected_results.size(), apply_grid_cmd(cur_cmd));
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          cur_cmd = pending_cmds.pop_front();
          req_if.cmd    <= cur_cmd.op;
          req_if.x_lo   <= cur_cmd.x_lo;
          req_if.y_lo   <= cur_cmd.y_lo;
          req_if.z_lo   <= cur_cmd.z_lo;
          req_if.x_hi   <= cur_cmd.x_hi;
          req_if.y_hi   <= cur_cmd.y_hi;
          req_if.z_hi   <= cur_cmd.z_hi;
          req_if.half_x <= cur_cmd.half_x;
          req_if.half_y <= cur_cmd.half_y;
          req_if.half_z <= cur_cmd.half_z;
          req_if.value  <= cur_cmd.value;
          req_if.valid  <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // Start a new burst; one in four follows with no gap at all.
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result monitor: compare each transfer against the oldest expectation and
  // step the ready pattern for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with nothing expected, fields", 0,
                          {rsp_if.cell_value, rsp_if.hit});
        end else begin
          if (rsp_if.cell_value !== expected_results[0].cell_value)
            report_mismatch("cell_value", expected_results[0].cell_value, rsp_if.cell_value);
          if (rsp_if.hit !== expected_results[0].hit)
            report_mismatch("hit", expected_results[0].hit, rsp_if.hit);
          void'(expected_results.pop_front());
        end
        result_count++;
      end
      if (pattern_pos == 15) begin
        // Reload: a quarter of the windows never stall.
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        pattern_pos = 0;
      end else begin
        pattern_pos++;
      end
      rsp_if.ready <= ready_pattern[pattern_pos];
    end
  end

  initial begin
    int i;
    clk = 1'b0;
    rst = 1'b1;
    // Drive every block input to a known value before the first edge.
    req_if.valid  = 1'b0;
    req_if.cmd    = CMD_READ;
    req_if.x_lo   = '0;
    req_if.y_lo   = '0;
    req_if.z_lo   = '0;
    req_if.x_hi   = '0;
    req_if.y_hi   = '0;
    req_if.z_hi   = '0;
    req_if.half_x = '0;
    req_if.half_y = '0;
    req_if.half_z = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    accepted_count = 0;
    result_count = 0;
    mismatch_count = 0;
    burst_left = 4;
    gap_left = 0;
    ready_pattern = 16'hffff;
    pattern_pos = 0;
    for (i = 0; i < GRID_CELLS; i++) voxel_map[i] = '0;

    // Directed part. Reads of the freshly cleared grid at both corners.
    add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, 15, 15, 15, 0, 0, 0, 0, 0, 0, 3));
    // Writes at the corners and one odd cell, then read them back.
    add_cmd(make_cmd(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_WRITE, 15, 15, 15, 0, 0, 0, 0, 0, 0, 2));
    add_cmd(make_cmd(CMD_WRITE, 15, 0, 7, 0, 0, 0, 0, 0, 0, 1));
    add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, 15, 15, 15, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, 15, 0, 7, 0, 0, 0, 0, 0, 0, 0));
    // Off-grid read returns zero; off-grid write is dropped.
    add_cmd(make_cmd(CMD_READ, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_WRITE, 16, 31, 0, 0, 0, 0, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_READ, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0));
    // Queries: whole grid, interior only, upper bound past the grid,
    // empty axis, low above high, and a zero mask.
    add_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 16, 16, 16, 0, 0, 0, 1));
    add_cmd(make_cmd(CMD_QUERY, 1, 1, 1, 15, 15, 15, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_QUERY, 15, 15, 15, 31, 31, 31, 0, 0, 0, 2));
    add_cmd(make_cmd(CMD_QUERY, 0, 5, 0, 16, 5, 16, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_QUERY, 10, 0, 0, 3, 16, 16, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 16, 16, 16, 0, 0, 0, 0));
    // Marks: center off the grid, zero extent, low bound saturating at the
    // corner, and a clearing pass over the whole grid from a zero center.
    add_cmd(make_cmd(CMD_MARK, 16, 3, 3, 0, 0, 0, 2, 2, 2, 3));
    add_cmd(make_cmd(CMD_MARK, 8, 8, 8, 0, 0, 0, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_MARK, 0, 0, 0, 0, 0, 0, 2, 2, 2, 0));
    add_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 3, 3, 3, 0, 0, 0, 3));
    add_cmd(make_cmd(CMD_MARK, 8, 8, 8, 0, 0, 0, 15, 15, 15, 0));
    // Upper bound clipping at the far corner, then probe around it.
    add_cmd(make_cmd(CMD_MARK, 15, 15, 15, 0, 0, 0, 1, 2, 3, 2));
    add_cmd(make_cmd(CMD_READ, 14, 15, 12, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 14, 16, 16, 0, 0, 0, 2));

    for (i = 0; i < RANDOM_CMDS; i++) add_cmd(rand_grid_cmd());
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to transfer and every result to come back,
    // then idle long enough to catch any stray result.
    wait (accepted_count == total_cmds);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, including the clear pass.
  initial begin
    #(20_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: voxel_marker_grid_engine_unit.f
hw/rtl/vmg_pkg.sv
hw/rtl/vmg_if.sv
hw/rtl/vmg_front.sv
hw/rtl/vmg_queue.sv
hw/rtl/vmg_back.sv
hw/rtl/voxel_marker_grid_engine_unit.sv
tb/sv/tb_top.sv
